// File: rtl/urfa_pkg.sv
// UART receive frame assembler: shared types and constants.
// No dependencies.
`timescale 1ns / 1ps

package urfa_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 6;
  localparam int IDLE_W      = 16;
  localparam int REG_IDX_W   = 2;
  localparam int CFG_W       = 16;
  localparam int S_USER_W    = 1;
  localparam int M_DATA_W    = 16;

  typedef enum logic [1:0] {
    CAUSE_TIMEOUT  = 2'd0,
    CAUSE_OVERFLOW = 2'd1,
    CAUSE_END_BYTE = 2'd2
  } cause_t;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_MODE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_END_BYTE   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_IDLE_LIMIT = 2'd2;

  localparam logic              MODE_TIMEOUT   = 1'b0;
  localparam logic              MODE_END_BYTE  = 1'b1;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'd10;
  localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST = 16'd10;

endpackage

// File: rtl/urfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module urfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/uart_rx_frame_assembler_unit.sv
// UART receive frame assembler top level: bytes and ticks in, closed frames out.
// Depends on urfa_pkg and urfa_ram (frame buffer).
// An input beat is taken only while idle; a closing beat moves the unit to the
// flush state, where each RAM read passes through rd_pend into the output register.
// One input beat per cycle is taken while no frame drains; a closed frame of N
// bytes drains one beat at a time, each RAM read waiting for the last to land and the output to free.
// Reset: synchronous, active high; registers to defaults, buffer empty.
`timescale 1ns / 1ps

module uart_rx_frame_assembler_unit #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [urfa_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] rx_byte
  input  logic [urfa_pkg::S_USER_W-1:0]   s_tuser,   // [0] opcode
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [urfa_pkg::M_DATA_W-1:0]   m_tdata,   // [7:0] frame_byte, [13:8] frame_length
  output logic                            m_tlast,   // last_of_frame
  output logic [1:0]                      m_tuser,   // [1:0] close_cause
  input  logic                            cfg_we,
  input  logic [urfa_pkg::REG_IDX_W-1:0]  cfg_addr,
  input  logic [urfa_pkg::CFG_W-1:0]      cfg_wdata
);

  import urfa_pkg::*;

  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam logic [ADDR_W-1:0] FULL_CNT = ADDR_W'(BUFFER_DEPTH - 1);

  typedef enum logic {ST_IDLE, ST_FLUSH} state_t;

  state_t              state;
  logic                frame_mode;
  logic [BYTE_W-1:0]   end_byte;
  logic [IDLE_W-1:0]   idle_limit;
  logic [ADDR_W-1:0]   fill;
  logic                frame_open;
  logic [IDLE_W-1:0]   idle_ticks;
  logic [ADDR_W-1:0]   flush_len;
  cause_t              cause;
  logic [ADDR_W-1:0]   rd_ptr;
  logic                rd_pend;
  logic                pend_last;
  logic [BYTE_W-1:0]   out_byte;
  logic [LEN_W-1:0]    out_len;
  cause_t              out_cause;
  logic                out_last;

  logic                in_beat;
  logic                is_byte;
  logic [ADDR_W-1:0]   fill_next;
  logic                full;
  logic                ended;
  logic [IDLE_W-1:0]   idle_next;
  logic                timeout;
  logic                rd_issue;
  logic [BYTE_W-1:0]   ram_rdata;

  assign s_tready  = (state == ST_IDLE);
  assign in_beat   = s_tvalid && s_tready;
  assign is_byte   = (s_tuser[0] == OP_BYTE);
  assign fill_next = fill + 1'b1;
  assign full      = (fill_next == FULL_CNT);
  assign ended     = (frame_mode == MODE_END_BYTE) && (s_tdata == end_byte);
  assign idle_next = (idle_ticks == '1) ? idle_ticks : idle_ticks + 1'b1;
  assign timeout   = idle_next > idle_limit;
  assign rd_issue  = (state == ST_FLUSH) && (rd_ptr != flush_len) && !rd_pend
                     && (!m_tvalid || m_tready);

  urfa_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_frame_store (
    .clk   (clk),
    .we    (in_beat && is_byte),
    .waddr (fill),
    .wdata (s_tdata),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode <= MODE_TIMEOUT;
      end_byte   <= END_BYTE_RST;
      idle_limit <= IDLE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_MODE: frame_mode <= cfg_wdata[0];
        REG_END_BYTE:   end_byte   <= cfg_wdata[BYTE_W-1:0];
        REG_IDLE_LIMIT: idle_limit <= cfg_wdata[IDLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill       <= '0;
      frame_open <= 1'b0;
      idle_ticks <= '0;
      rd_ptr     <= '0;
      rd_pend    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            if (is_byte) begin
              idle_ticks <= '0;
              if (ended || full) begin
                state      <= ST_FLUSH;
                flush_len  <= fill_next;
                cause      <= ended ? CAUSE_END_BYTE : CAUSE_OVERFLOW;
                rd_ptr     <= '0;
                fill       <= '0;
                frame_open <= 1'b0;
              end else begin
                fill       <= fill_next;
                frame_open <= 1'b1;
              end
            end else if (frame_mode == MODE_TIMEOUT && frame_open) begin
              if (timeout) begin
                state      <= ST_FLUSH;
                flush_len  <= fill;
                cause      <= CAUSE_TIMEOUT;
                rd_ptr     <= '0;
                fill       <= '0;
                frame_open <= 1'b0;
                idle_ticks <= '0;
              end else begin
                idle_ticks <= idle_next;
              end
            end
          end
        end
        ST_FLUSH: begin
          if (rd_issue) begin
            rd_ptr    <= rd_ptr + 1'b1;
            pend_last <= (ADDR_W'(rd_ptr + 1'b1) == flush_len);
          end
          if (!rd_issue && !rd_pend && rd_ptr == flush_len) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      rd_pend <= rd_issue;

      if (rd_pend) begin
        m_tvalid  <= 1'b1;
        out_byte  <= ram_rdata;
        out_last  <= pend_last;
        out_len   <= LEN_W'(flush_len);
        out_cause <= cause;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {{(M_DATA_W - LEN_W - BYTE_W){1'b0}}, out_len, out_byte};
  assign m_tlast = out_last;
  assign m_tuser = out_cause;

  a_land_empty: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> !m_tvalid)
    else $error("read data lands on a held output beat");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (fill < FULL_CNT))
    else $error("fill count reached overflow level while idle");

  a_open_fill: assert property (@(posedge clk) disable iff (rst)
    !frame_open |-> (fill == '0))
    else $error("bytes buffered with no open frame");

  a_cause_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == CAUSE_TIMEOUT || m_tuser == CAUSE_OVERFLOW
                  || m_tuser == CAUSE_END_BYTE))
    else $error("illegal close cause on output");

  a_rd_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> (rd_ptr <= flush_len))
    else $error("read pointer past frame length");

endmodule
